// File: rtl/abi_pkg.sv
package abi_pkg;

  // Field and register widths fixed by the interface.
  localparam int unsigned OP_W        = 2;
  localparam int unsigned RND_W       = 32;
  localparam int unsigned MIN_W       = 10;
  localparam int unsigned MAX_W       = 11;
  localparam int unsigned STEP_W      = 8;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned PERIOD_W    = 12;
  localparam int unsigned DELAY_W     = 21;
  localparam int unsigned EXPECT_W    = 16;
  // Start span min_interval_s * 1000 fits in this many bits.
  localparam int unsigned SPAN_W      = 20;

  // Default counter width.
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Timing constants.
  localparam int unsigned MS_PER_S        = 1000;
  localparam int unsigned REFRESH_BASE_MS = 500;
  localparam int unsigned START_EXPECTED  = 2;

  // Reciprocals for q/10 and (q/4)/15, exact for 12-bit periods.
  localparam int unsigned RECIP_10    = 3277;
  localparam int unsigned RECIP_15    = 2185;
  localparam int unsigned RECIP_SHIFT = 15;

  // Reset values.
  localparam logic [MIN_W-1:0]    MIN_RST    = MIN_W'(10);
  localparam logic [MAX_W-1:0]    MAX_RST    = MAX_W'(600);
  localparam logic [STEP_W-1:0]   STEP_UP_RST = STEP_W'(10);
  localparam logic [STEP_W-1:0]   STEP_DN_RST = STEP_W'(20);
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(20);

  // Request operations.
  typedef enum logic [OP_W-1:0] {
    OP_SEEN    = 2'd0,
    OP_EXPIRE  = 2'd1,
    OP_REFRESH = 2'd2,
    OP_START   = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_INTERVAL = 2'd0,
    REG_MAX_INTERVAL = 2'd1,
    REG_STEP_UP      = 2'd2,
    REG_STEP_DOWN    = 2'd3
  } cfg_reg_e;

  // Handshake between the controller and the serial divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// File: rtl/adaptive_beacon_interval.sv
// Adaptive beacon interval controller for one network key.
// Input channel (in_valid_i / in_stall_o) carries one event request: op_i selects
// beacon seen, timer expired, state refreshed or start beaconing, and random_word_i
// feeds the refresh and start delays. Every request gives exactly one result on the
// output channel (out_valid_o / out_stall_i): send_beacon, rearm with delay_ms, the
// adapted flag and the current period and expected count.
// One request is processed at a time. Beacon-seen requests, non-adapting expiry
// requests and start requests with a zero minimum interval go straight to the done
// state and from there into the output register. Refresh and other start requests
// go through the bit-serial divider. An adapting expiry adds a 12-step shift-add
// multiply before the divide, then the adjust and expected-count steps. DIV_W is
// the larger of 32 and COUNT_BITS + 12; the divider settles one quotient bit per cycle.
// The result sits in an output register, so a new request is accepted while the
// previous result waits; if the receiver stalls, the next result is held in the
// final state until the output register frees, and no further request is taken.
// Configuration writes take effect at once and must only be made while idle.
// Reset restores the register defaults, a 20 s period, an expected count of two,
// a zero seen count and the half-period phase, and empties the output register.
module adaptive_beacon_interval #(
  parameter int unsigned COUNT_BITS = abi_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Event requests.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [abi_pkg::OP_W-1:0]        op_i,
  input  logic [abi_pkg::RND_W-1:0]       random_word_i,
  // Results.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            send_beacon_o,
  output logic                            rearm_o,
  output logic [abi_pkg::DELAY_W-1:0]     delay_ms_o,
  output logic                            adapted_o,
  output logic [abi_pkg::PERIOD_W-1:0]    period_s_o,
  output logic [abi_pkg::EXPECT_W-1:0]    expected_count_o,
  // Configuration writes.
  input  logic                            cfg_we_i,
  input  logic [abi_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [abi_pkg::CFG_W-1:0]       cfg_data_i
);
  import abi_pkg::*;

  localparam int unsigned PROD_W = PERIOD_W + COUNT_BITS;
  localparam int unsigned DIV_W  = (PROD_W > RND_W) ? PROD_W : RND_W;
  localparam int unsigned DEN_W  = (COUNT_BITS > SPAN_W) ? COUNT_BITS : SPAN_W;
  localparam int unsigned ADJ_W  = DIV_W + 1;
  localparam int unsigned MUL_CNT_W = $clog2(PERIOD_W);
  localparam int unsigned EXP_W  = 11;
  localparam int unsigned SAT_W  = (COUNT_BITS > EXP_W) ? COUNT_BITS : EXP_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_ADJ  = 6'b001000,
    ST_EXP  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // Registers.
  state_e                 state_q, state_d;
  op_e                    op_q, op_d;
  logic                   adapt_q, adapt_d;
  logic                   half_q, half_d;
  logic [PERIOD_W-1:0]    period_q, period_d;
  logic [COUNT_BITS-1:0]  seen_q, seen_d;
  logic [COUNT_BITS-1:0]  expected_q, expected_d;
  logic [MIN_W-1:0]       min_q;
  logic [MAX_W-1:0]       max_q;
  logic [STEP_W-1:0]      step_up_q;
  logic [STEP_W-1:0]      step_dn_q;
  logic [PROD_W-1:0]      acc_q, acc_d;
  logic [PERIOD_W-1:0]    mpl_q, mpl_d;
  logic [MUL_CNT_W-1:0]   mul_cnt_q, mul_cnt_d;

  logic                   out_valid_q, out_valid_d;
  logic                   send_q, rearm_q, adapted_q;
  logic [DELAY_W-1:0]     delay_q;
  logic [PERIOD_W-1:0]    period_out_q;
  logic [EXPECT_W-1:0]    expected_out_q;

  // Divider connection.
  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [DIV_W-1:0]       div_dividend;
  logic [DEN_W-1:0]       div_divisor;
  logic [DIV_W-1:0]       div_quot;
  logic [DEN_W-1:0]       div_rem;

  logic                   in_accept;
  op_e                    op_in;
  logic                   out_load;
  logic [SPAN_W-1:0]      start_span;

  // Period adjustment terms.
  logic [ADJ_W-1:0]       q_ext, up_lim, period_ext, floor_ext, ceil_ext, q_step, q_clamp;
  logic                   go_up, go_down;

  // Expected count terms.
  logic [2*PERIOD_W-1:0]  prod_10;
  logic [2*PERIOD_W-3:0]  prod_60;
  logic [EXP_W-1:0]       exp_sum;
  logic [SAT_W-1:0]       exp_ext;
  logic [COUNT_BITS-1:0]  exp_sat;

  // Result fields.
  logic                   res_send, res_rearm;
  logic [DELAY_W-1:0]     res_delay;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign op_in      = op_e'(op_i);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign start_span = SPAN_W'(min_q) * SPAN_W'(MS_PER_S);

  // Step limits, then the floor and ceiling clamp on the new quotient.
  assign q_ext      = {1'b0, div_quot};
  assign period_ext = ADJ_W'(period_q);
  assign up_lim     = ADJ_W'(period_q) + ADJ_W'(step_up_q);
  assign go_up      = q_ext > up_lim;
  assign go_down    = (q_ext + ADJ_W'(step_dn_q)) < period_ext;
  assign floor_ext  = ADJ_W'({min_q, 1'b0});
  assign ceil_ext   = ADJ_W'({max_q, 1'b0});

  always_comb begin
    priority if (go_up) begin
      q_step = up_lim;
    end else if (go_down) begin
      q_step = ADJ_W'(period_q - PERIOD_W'(step_dn_q));
    end else begin
      q_step = q_ext;
    end
    priority if (q_step < floor_ext) begin
      q_clamp = floor_ext;
    end else if (q_step > ceil_ext) begin
      q_clamp = ceil_ext;
    end else begin
      q_clamp = q_step;
    end
  end

  // Expected count q/10 + 3*(q/60) by reciprocal multiplies on the new period.
  assign prod_10 = (2*PERIOD_W)'(period_q) * (2*PERIOD_W)'(RECIP_10);
  assign prod_60 = (2*PERIOD_W-2)'(period_q[PERIOD_W-1:2]) * (2*PERIOD_W-2)'(RECIP_15);
  assign exp_sum = EXP_W'(prod_10[2*PERIOD_W-1:RECIP_SHIFT])
                 + EXP_W'({prod_60[2*PERIOD_W-3:RECIP_SHIFT], 1'b0})
                 + EXP_W'(prod_60[2*PERIOD_W-3:RECIP_SHIFT]);
  assign exp_ext = SAT_W'(exp_sum);
  assign exp_sat = (exp_ext > SAT_W'(COUNT_MAX)) ? COUNT_MAX : exp_ext[COUNT_BITS-1:0];

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    adapt_d      = adapt_q;
    half_d       = half_q;
    period_d     = period_q;
    seen_d       = seen_q;
    expected_d   = expected_q;
    acc_d        = acc_q;
    mpl_d        = mpl_q;
    mul_cnt_d    = mul_cnt_q;
    div_req      = '0;
    div_dividend = DIV_W'(random_word_i);
    div_divisor  = DEN_W'(MS_PER_S);
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op_d    = op_in;
          adapt_d = 1'b0;
          state_d = ST_DONE;
          unique case (op_in)
            OP_SEEN: begin
              seen_d = sat_inc(seen_q);
            end
            OP_EXPIRE: begin
              seen_d = sat_inc(seen_q);
              half_d = !half_q;
              if (!half_q) begin
                adapt_d   = 1'b1;
                acc_d     = '0;
                mpl_d     = period_q;
                mul_cnt_d = '0;
                state_d   = ST_MUL;
              end
            end
            OP_REFRESH: begin
              expected_d    = sat_inc(expected_q);
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end
            OP_START: begin
              period_d   = PERIOD_W'({min_q, 1'b0});
              expected_d = COUNT_BITS'(START_EXPECTED);
              seen_d     = '0;
              half_d     = 1'b1;
              // A zero minimum interval gives a fixed 1 ms delay.
              if (min_q != '0) begin
                div_req.start = 1'b1;
                div_divisor   = DEN_W'(start_span);
                state_d       = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        // MSB-first shift-add of period by seen count.
        acc_d     = {acc_q[PROD_W-2:0], 1'b0} + (mpl_q[PERIOD_W-1] ? PROD_W'(seen_q) : '0);
        mpl_d     = {mpl_q[PERIOD_W-2:0], 1'b0};
        mul_cnt_d = mul_cnt_q + 1'b1;
        if (mul_cnt_q == MUL_CNT_W'(PERIOD_W - 1)) begin
          div_req.start = 1'b1;
          div_dividend  = DIV_W'(acc_d);
          div_divisor   = DEN_W'(expected_q);
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = (op_q == OP_EXPIRE) ? ST_ADJ : ST_DONE;
        end
      end
      ST_ADJ: begin
        period_d = q_clamp[PERIOD_W-1:0];
        seen_d   = '0;
        state_d  = ST_EXP;
      end
      ST_EXP: begin
        expected_d = exp_sat;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result fields for the finished request.
  always_comb begin
    res_send  = (op_q == OP_EXPIRE);
    res_rearm = (op_q != OP_SEEN);
    unique case (op_q)
      OP_SEEN:    res_delay = '0;
      OP_EXPIRE:  res_delay = DELAY_W'(period_q[PERIOD_W-1:1]) * DELAY_W'(MS_PER_S);
      OP_REFRESH: res_delay = DELAY_W'(REFRESH_BASE_MS) + DELAY_W'(div_rem);
      OP_START:   res_delay = (min_q == '0) ? DELAY_W'(1) : DELAY_W'(div_rem) + DELAY_W'(1);
      default:    res_delay = '0;
    endcase
  end

  // Output register handshake.
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_SEEN;
      adapt_q     <= 1'b0;
      half_q      <= 1'b1;
      period_q    <= PERIOD_RST;
      seen_q      <= '0;
      expected_q  <= COUNT_BITS'(START_EXPECTED);
      mul_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      adapt_q     <= adapt_d;
      half_q      <= half_d;
      period_q    <= period_d;
      seen_q      <= seen_d;
      expected_q  <= expected_d;
      mul_cnt_q   <= mul_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= MIN_RST;
      max_q     <= MAX_RST;
      step_up_q <= STEP_UP_RST;
      step_dn_q <= STEP_DN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MIN_INTERVAL: min_q     <= cfg_data_i[MIN_W-1:0];
        REG_MAX_INTERVAL: max_q     <= cfg_data_i[MAX_W-1:0];
        REG_STEP_UP:      step_up_q <= cfg_data_i[STEP_W-1:0];
        REG_STEP_DOWN:    step_dn_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Multiplier shift registers and result payload.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mpl_q <= mpl_d;
    if (out_load) begin
      send_q         <= res_send;
      rearm_q        <= res_rearm;
      delay_q        <= res_delay;
      adapted_q      <= adapt_q;
      period_out_q   <= period_q;
      expected_out_q <= EXPECT_W'(expected_q);
    end
  end

  abi_div #(
    .NUM_W (DIV_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .rsp_o       (div_rsp),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign out_valid_o      = out_valid_q;
  assign send_beacon_o    = send_q;
  assign rearm_o          = rearm_q;
  assign delay_ms_o       = delay_q;
  assign adapted_o        = adapted_q;
  assign period_s_o       = period_out_q;
  assign expected_count_o = expected_out_q;

  // A beacon-seen request goes straight to the result state.
  a_seen_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && op_in == OP_SEEN) |=> (state_q == ST_DONE))
    else $error("beacon-seen request did not finish at once");

  // A new result appears only when the sequencer hands one over.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result appeared outside the done state");

  // The divider is started only from idle or at the end of the multiply.
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (state_q == ST_IDLE || state_q == ST_MUL))
    else $error("divider started from an unexpected state");

  // While waiting on the divider it must be running or finishing.
  a_div_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting on an idle divider");

  // The clamped period never reaches the all-ones code.
  a_adj_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADJ) |=> (period_q != '1))
    else $error("adapted period out of range");

endmodule

// File: rtl/abi_div.sv
module abi_div #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  abi_pkg::div_req_t   req_i,
  input  logic [NUM_W-1:0]    dividend_i,
  input  logic [DEN_W-1:0]    divisor_i,
  output abi_pkg::div_rsp_t   rsp_o,
  output logic [NUM_W-1:0]    quotient_o,
  output logic [DEN_W-1:0]    remainder_o
);
  import abi_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;

  logic             next_bit;
  logic [DEN_W+1:0] diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try the subtraction.
  assign next_bit = quo_q[NUM_W-1];
  assign diff     = {1'b0, rem_q, next_bit} - {2'b00, den_q};
  assign fits     = ~diff[DEN_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DEN_W-1:0] : {rem_q[DEN_W-2:0], next_bit};
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= divisor_i;
    end
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  // A step count never runs past the dividend width.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q < CNT_W'(NUM_W)))
    else $error("divider step count out of range");

  // Completion follows the last step of a busy run.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a finished run");

  // A start always opens a run.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q)
    else $error("divider start did not open a run");

endmodule
